// ----- hw/rtl/ffed_pkg.sv -----
// Shared types, character codes and hex helpers for the form field decoder.
// Used by ffed_step and form_field_extract_decode_core; no dependencies.
`timescale 1ns / 1ps
package ffed_pkg;

  localparam int NUM_RES = 4;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic KIND_BYTE   = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  localparam logic [1:0] CFG_KEY_CHARS  = 2'd0;
  localparam logic [1:0] CFG_KEY_LENGTH = 2'd1;
  localparam logic [1:0] CFG_CAPACITY   = 2'd2;

  typedef enum logic [1:0] {
    PH_MATCH = 2'd0,
    PH_SKIP  = 2'd1,
    PH_VALUE = 2'd2,
    PH_DONE  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ESC_NONE = 2'd0,
    ESC_ONE  = 2'd1,
    ESC_TWO  = 2'd2
  } esc_t;

  typedef struct packed {
    phase_t     phase;
    logic [3:0] key_pos;
    logic [7:0] raw_cnt;
    esc_t       esc;
    logic [7:0] held;
  } state_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] value_byte;
    logic       found;
    logic       run_last;
  } result_t;

  typedef result_t [NUM_RES-1:0] res_vec_t;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
           (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) v = 4'(c - 8'h30);
    else if (c >= 8'h61 && c <= 8'h66) v = 4'(c - 8'h57);
    else if (c >= 8'h41 && c <= 8'h46) v = 4'(c - 8'h37);
    return v;
  endfunction

  function automatic result_t mk_res(input logic kind, input logic [7:0] b,
                                     input logic found);
    result_t r;
    r.kind       = kind;
    r.value_byte = b;
    r.found      = found;
    r.run_last   = 1'b0;
    return r;
  endfunction

endpackage

// ----- hw/rtl/ffed_step.sv -----
// Next-state and result logic for one body byte of the form field decoder.
// Depends on ffed_pkg.
`timescale 1ns / 1ps
module ffed_step #(
  parameter int MAX_KEY_BYTES = 8
) (
  input  ffed_pkg::state_t   st,
  input  logic [7:0]         body_byte,
  input  logic               body_end,
  input  logic [63:0]        key_chars,
  input  logic [3:0]         key_length,
  input  logic [7:0]         value_capacity,
  output ffed_pkg::state_t   st_nxt,
  output ffed_pkg::res_vec_t res,
  output logic [2:0]         res_cnt
);

  localparam logic [3:0] MAX_KEY = 4'(MAX_KEY_BYTES);

  ffed_pkg::state_t   s;
  ffed_pkg::res_vec_t r;
  logic [2:0]         n;
  logic [3:0]         klen;
  logic [7:0]         limit;
  logic [7:0]         kb;
  logic               fin;
  logic               plain;
  logic [7:0]         b;

  always_comb begin
    b     = body_byte;
    s     = st;
    r     = '0;
    n     = 3'd0;
    fin   = 1'b0;
    plain = 1'b0;
    klen  = (key_length > MAX_KEY) ? MAX_KEY : key_length;
    limit = (value_capacity == 8'd0) ? 8'd0 : value_capacity - 8'd1;
    kb    = key_chars[{s.key_pos[2:0], 3'b000} +: 8];

    case (st.phase)
      ffed_pkg::PH_MATCH: begin
        if (b == ffed_pkg::CH_AMP) begin
          s.key_pos = 4'd0;
        end else if (s.key_pos < klen) begin
          if (b == kb) s.key_pos = s.key_pos + 4'd1;
          else s.phase = ffed_pkg::PH_SKIP;
        end else if (b == ffed_pkg::CH_EQ) begin
          s.phase   = ffed_pkg::PH_VALUE;
          s.raw_cnt = 8'd0;
          s.esc     = ffed_pkg::ESC_NONE;
          s.held    = 8'd0;
          if (limit == 8'd0) fin = 1'b1;
        end else begin
          s.phase = ffed_pkg::PH_SKIP;
        end
      end
      ffed_pkg::PH_SKIP: begin
        if (b == ffed_pkg::CH_AMP) begin
          s.phase   = ffed_pkg::PH_MATCH;
          s.key_pos = 4'd0;
        end
      end
      ffed_pkg::PH_VALUE: begin
        if (b == ffed_pkg::CH_AMP || s.raw_cnt >= limit) begin
          fin = 1'b1;
        end else begin
          s.raw_cnt = s.raw_cnt + 8'd1;
          case (s.esc)
            ffed_pkg::ESC_ONE: begin
              if (ffed_pkg::is_hex(b)) begin
                s.held = b;
                s.esc  = ffed_pkg::ESC_TWO;
              end else begin
                s.esc = ffed_pkg::ESC_NONE;
                r[n[1:0]] = ffed_pkg::mk_res(ffed_pkg::KIND_BYTE, ffed_pkg::CH_PCT, 1'b0);
                n = n + 3'd1;
                plain = 1'b1;
              end
            end
            ffed_pkg::ESC_TWO: begin
              s.esc = ffed_pkg::ESC_NONE;
              if (ffed_pkg::is_hex(b)) begin
                r[n[1:0]] = ffed_pkg::mk_res(ffed_pkg::KIND_BYTE,
                  {ffed_pkg::hex_val(s.held), ffed_pkg::hex_val(b)}, 1'b0);
                n = n + 3'd1;
              end else begin
                r[n[1:0]] = ffed_pkg::mk_res(ffed_pkg::KIND_BYTE, ffed_pkg::CH_PCT, 1'b0);
                n = n + 3'd1;
                r[n[1:0]] = ffed_pkg::mk_res(ffed_pkg::KIND_BYTE, s.held, 1'b0);
                n = n + 3'd1;
                plain = 1'b1;
              end
            end
            default: plain = 1'b1;
          endcase
          if (plain) begin
            if (b == ffed_pkg::CH_PLUS) begin
              r[n[1:0]] = ffed_pkg::mk_res(ffed_pkg::KIND_BYTE, ffed_pkg::CH_SPACE, 1'b0);
              n = n + 3'd1;
            end else if (b == ffed_pkg::CH_PCT) begin
              s.esc = ffed_pkg::ESC_ONE;
            end else begin
              r[n[1:0]] = ffed_pkg::mk_res(ffed_pkg::KIND_BYTE, b, 1'b0);
              n = n + 3'd1;
            end
          end
          if (s.raw_cnt >= limit) fin = 1'b1;
        end
      end
      default: ;
    endcase

    if (body_end && !fin) begin
      if (s.phase == ffed_pkg::PH_VALUE) begin
        fin = 1'b1;
      end else if (s.phase == ffed_pkg::PH_MATCH || s.phase == ffed_pkg::PH_SKIP) begin
        r[n[1:0]] = ffed_pkg::mk_res(ffed_pkg::KIND_REPORT, 8'd0, 1'b0);
        n = n + 3'd1;
      end
    end

    if (fin) begin
      if (s.esc == ffed_pkg::ESC_ONE || s.esc == ffed_pkg::ESC_TWO) begin
        r[n[1:0]] = ffed_pkg::mk_res(ffed_pkg::KIND_BYTE, ffed_pkg::CH_PCT, 1'b0);
        n = n + 3'd1;
      end
      if (s.esc == ffed_pkg::ESC_TWO) begin
        r[n[1:0]] = ffed_pkg::mk_res(ffed_pkg::KIND_BYTE, s.held, 1'b0);
        n = n + 3'd1;
      end
      s.esc = ffed_pkg::ESC_NONE;
      r[n[1:0]] = ffed_pkg::mk_res(ffed_pkg::KIND_REPORT, 8'd0, 1'b1);
      n = n + 3'd1;
      s.phase = ffed_pkg::PH_DONE;
    end

    if (body_end) begin
      s.phase   = ffed_pkg::PH_MATCH;
      s.key_pos = 4'd0;
      s.raw_cnt = 8'd0;
      s.esc     = ffed_pkg::ESC_NONE;
      s.held    = 8'd0;
    end

    for (int i = 0; i < ffed_pkg::NUM_RES; i++) begin
      r[i].run_last = (3'(i + 1) == n);
    end
  end

  assign st_nxt  = s;
  assign res     = r;
  assign res_cnt = n;

endmodule

// ----- hw/rtl/form_field_extract_decode_core.sv -----
// Form-urlencoded field extractor and value decoder, top level.
// Depends on ffed_pkg and ffed_step.
// Results of a byte are registered and appear on out_* in the cycle after it is accepted.
// Throughput: one byte per cycle while out_tready is high and each byte gives at most one
//   result; a byte giving more results holds the input while its result group drains.
// Reset: rst_n synchronous, active low; registers return to key 0, length 4, capacity 64.
`timescale 1ns / 1ps
module form_field_extract_decode_core #(
  parameter int MAX_KEY_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] body_byte
  input  logic        in_tlast,   // body_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] value_byte, [8] found, [15:9] zero
  output logic        out_tuser,  // [0] kind
  output logic        out_tlast,  // run_last
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [63:0] cfg_wdata
);

  logic [63:0]        key_chars_r;
  logic [3:0]         key_length_r;
  logic [7:0]         capacity_r;
  ffed_pkg::state_t   st_r;
  ffed_pkg::state_t   st_nxt;
  ffed_pkg::res_vec_t grp_r;
  ffed_pkg::res_vec_t step_res;
  logic [2:0]         step_cnt;
  logic [2:0]         rem_r;
  logic [1:0]         idx_r;
  logic               in_fire;
  logic               out_fire;
  ffed_pkg::result_t  cur;

  ffed_step #(.MAX_KEY_BYTES(MAX_KEY_BYTES)) u_step (
    .st             (st_r),
    .body_byte      (in_tdata),
    .body_end       (in_tlast),
    .key_chars      (key_chars_r),
    .key_length     (key_length_r),
    .value_capacity (capacity_r),
    .st_nxt         (st_nxt),
    .res            (step_res),
    .res_cnt        (step_cnt)
  );

  assign cur        = grp_r[idx_r];
  assign out_tvalid = (rem_r != 3'd0);
  assign out_fire   = out_tvalid && out_tready;
  assign in_tready  = (rem_r == 3'd0) || (rem_r == 3'd1 && out_tready);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tdata  = {7'd0, cur.found, cur.value_byte};
  assign out_tuser  = cur.kind;
  assign out_tlast  = cur.run_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_chars_r  <= 64'd0;
      key_length_r <= 4'd4;
      capacity_r   <= 8'd64;
    end else if (cfg_we) begin
      case (cfg_addr)
        ffed_pkg::CFG_KEY_CHARS:  key_chars_r  <= cfg_wdata;
        ffed_pkg::CFG_KEY_LENGTH: key_length_r <= cfg_wdata[3:0];
        ffed_pkg::CFG_CAPACITY:   capacity_r   <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase   <= ffed_pkg::PH_MATCH;
      st_r.key_pos <= 4'd0;
      st_r.raw_cnt <= 8'd0;
      st_r.esc     <= ffed_pkg::ESC_NONE;
      st_r.held    <= 8'd0;
      rem_r        <= 3'd0;
      idx_r        <= 2'd0;
    end else begin
      if (in_fire) begin
        st_r <= st_nxt;
      end
      if (in_fire && step_cnt != 3'd0) begin
        rem_r <= step_cnt;
        idx_r <= 2'd0;
      end else if (out_fire) begin
        rem_r <= rem_r - 3'd1;
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && step_cnt != 3'd0) begin
      grp_r <= step_res;
    end
  end

`ifndef SYNTH
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rem_r <= 3'd4)
    else $error("result group count out of range");

  a_last_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (rem_r == 3'd1)))
    else $error("last flag does not line up with group end");

  a_report_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == ffed_pkg::KIND_REPORT) |-> out_tlast)
    else $error("field report is not the final word of its byte");

  a_done_no_esc: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.phase == ffed_pkg::PH_DONE) |-> (st_r.esc == ffed_pkg::ESC_NONE))
    else $error("escape left pending after value end");
`endif

endmodule
